// ===== rtl/charger_fault_shutdown_sequencer_top_assert.svh =====
// Assertion macros shared by the shutdown sequencer modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef CHARGER_FAULT_SHUTDOWN_SEQUENCER_TOP_ASSERT_SVH
`define CHARGER_FAULT_SHUTDOWN_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CFSS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfss assertion failed");

// Next-cycle implication, checked outside reset.
`define CFSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfss assertion failed");

`endif

// ===== rtl/cfss_pkg.sv =====
// Types and constants for the charger fault shutdown sequencer.
// No dependencies; used by every module of the block.
package cfss_pkg;

    localparam int unsigned STOP_COUNT_W  = 6;
    localparam int unsigned ERROR_COUNT_W = 3;

    localparam logic [STOP_COUNT_W-1:0]  STOP_COUNT_MAX  = 6'd63;
    localparam logic [ERROR_COUNT_W-1:0] ERROR_COUNT_MAX = 3'd7;

    // Configuration register indexes.
    localparam logic [2:0] CFG_STOP_FRAME_INTERVAL  = 3'd0;
    localparam logic [2:0] CFG_ERROR_FRAME_INTERVAL = 3'd1;
    localparam logic [2:0] CFG_LOW_CURRENT_LEVEL    = 3'd2;
    localparam logic [2:0] CFG_CURRENT_TIMEOUT      = 3'd3;
    localparam logic [2:0] CFG_SAFE_VOLTAGE_LEVEL   = 3'd4;
    localparam logic [2:0] CFG_DRAIN_TIMEOUT        = 3'd5;
    localparam logic [2:0] CFG_CONNECTOR_TIMEOUT    = 3'd6;
    localparam logic [2:0] CFG_ERROR_PENDING        = 3'd7;

    typedef struct packed {
        logic [15:0] stop_frame_interval;
        logic [15:0] error_frame_interval;
        logic [15:0] low_current_level;
        logic [15:0] current_timeout;
        logic [15:0] safe_voltage_level;
        logic [15:0] drain_timeout;
        logic [15:0] connector_timeout;
        logic        error_pending;
    } cfss_cfg_t;

    typedef struct packed {
        logic        start_req;
        logic [31:0] now;
        logic [15:0] module_current;
        logic [15:0] module_voltage;
        logic        connector_present;
        logic [6:0]  fault_flags;
    } cfss_item_t;

    typedef struct packed {
        logic send_stop_frame;
        logic send_error_frame;
        logic bms_power_on;
        logic lock_on;
        logic module_off;
        logic output_open;
        logic charge_ended;
        logic gun_removed;
        logic go_idle;
    } cfss_result_t;

endpackage

// ===== rtl/cfss_cfg_regs.sv =====
// Configuration register file of the shutdown sequencer.
// Depends on cfss_pkg for the register indexes and the settings struct.
module cfss_cfg_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    output cfss_pkg::cfss_cfg_t  cfg
);
    import cfss_pkg::*;

    cfss_cfg_t cfg_reg;

    // Writes are always taken at once.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stop_frame_interval  <= 16'd10;
            cfg_reg.error_frame_interval <= 16'd250;
            cfg_reg.low_current_level    <= 16'd50;
            cfg_reg.current_timeout      <= 16'd120;
            cfg_reg.safe_voltage_level   <= 16'd600;
            cfg_reg.drain_timeout        <= 16'd4000;
            cfg_reg.connector_timeout    <= 16'd100;
            cfg_reg.error_pending        <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_STOP_FRAME_INTERVAL:  cfg_reg.stop_frame_interval  <= cfg_data;
                CFG_ERROR_FRAME_INTERVAL: cfg_reg.error_frame_interval <= cfg_data;
                CFG_LOW_CURRENT_LEVEL:    cfg_reg.low_current_level    <= cfg_data;
                CFG_CURRENT_TIMEOUT:      cfg_reg.current_timeout      <= cfg_data;
                CFG_SAFE_VOLTAGE_LEVEL:   cfg_reg.safe_voltage_level   <= cfg_data;
                CFG_DRAIN_TIMEOUT:        cfg_reg.drain_timeout        <= cfg_data;
                CFG_CONNECTOR_TIMEOUT:    cfg_reg.connector_timeout    <= cfg_data;
                CFG_ERROR_PENDING:        cfg_reg.error_pending        <= cfg_data[0];
            endcase
        end
    end

endmodule

// ===== rtl/cfss_pass.sv =====
// Sequencer state registers and the combinational logic of one control pass.
// Depends on cfss_pkg and the assertion macro header.
`include "charger_fault_shutdown_sequencer_top_assert.svh"

module cfss_pass #(
    parameter int unsigned STOP_FRAME_REPEATS  = 50,
    parameter int unsigned ERROR_FRAME_REPEATS = 5
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  cfss_pkg::cfss_item_t   item,
    input  cfss_pkg::cfss_cfg_t    cfg,
    output cfss_pkg::cfss_result_t result
);
    import cfss_pkg::*;

    localparam logic [STOP_COUNT_W-1:0]  STOP_LIMIT  = STOP_COUNT_W'(STOP_FRAME_REPEATS);
    localparam logic [ERROR_COUNT_W-1:0] ERROR_LIMIT = ERROR_COUNT_W'(ERROR_FRAME_REPEATS);

    function automatic logic elapsed_over(input logic [31:0] now_tick,
                                          input logic [31:0] stamp,
                                          input logic [15:0] limit);
        logic [31:0] diff;
        diff = now_tick - stamp;
        return diff > {16'd0, limit};
    endfunction

    logic                     stop_active_reg,    stop_active_next;
    logic [31:0]              stop_stamp_reg,     stop_stamp_next;
    logic [STOP_COUNT_W-1:0]  stop_count_reg,     stop_count_next;
    logic                     error_active_reg,   error_active_next;
    logic [31:0]              error_stamp_reg,    error_stamp_next;
    logic [ERROR_COUNT_W-1:0] error_count_reg,    error_count_next;
    logic                     current_active_reg, current_active_next;
    logic [31:0]              current_stamp_reg,  current_stamp_next;
    logic                     drain_active_reg,   drain_active_next;
    logic [31:0]              drain_stamp_reg,    drain_stamp_next;
    logic                     absent_active_reg,  absent_active_next;
    logic [31:0]              absent_stamp_reg,   absent_stamp_next;
    logic                     ended_reg,          ended_next;
    logic                     removed_reg,        removed_next;
    logic                     bms_power_reg,      bms_power_next;
    logic                     lock_reg,           lock_next;

    always_comb
    begin
        stop_active_next    = stop_active_reg;
        stop_stamp_next     = stop_stamp_reg;
        stop_count_next     = stop_count_reg;
        error_active_next   = error_active_reg;
        error_stamp_next    = error_stamp_reg;
        error_count_next    = error_count_reg;
        current_active_next = current_active_reg;
        current_stamp_next  = current_stamp_reg;
        drain_active_next   = drain_active_reg;
        drain_stamp_next    = drain_stamp_reg;
        absent_active_next  = absent_active_reg;
        absent_stamp_next   = absent_stamp_reg;
        ended_next          = ended_reg;
        removed_next        = removed_reg;
        bms_power_next      = bms_power_reg;
        lock_next           = lock_reg;
        result              = '0;

        // Entry actions of a start transaction.
        if (item.start_req)
        begin
            ended_next          = 1'b0;
            removed_next        = 1'b0;
            absent_active_next  = 1'b0;
            absent_stamp_next   = '0;
            bms_power_next      = 1'b1;
            lock_next           = 1'b1;
            result.module_off   = 1'b1;
            stop_count_next     = '0;
            result.send_stop_frame = 1'b1;
            stop_active_next    = 1'b1;
            stop_stamp_next     = item.now;
            error_count_next    = '0;
            result.send_error_frame = 1'b1;
            error_active_next   = 1'b1;
            error_stamp_next    = item.now;
            current_active_next = 1'b1;
            current_stamp_next  = item.now;
            drain_active_next   = 1'b0;
            drain_stamp_next    = '0;
        end

        if (stop_active_next &&
            elapsed_over(item.now, stop_stamp_next, cfg.stop_frame_interval))
        begin
            result.send_stop_frame = 1'b1;
            stop_stamp_next = item.now;
            if (stop_count_next < STOP_COUNT_MAX)
                stop_count_next = stop_count_next + STOP_COUNT_W'(1);
            if (stop_count_next > STOP_LIMIT || stop_count_next == STOP_COUNT_MAX)
                stop_active_next = 1'b0;
        end

        if (error_active_next &&
            elapsed_over(item.now, error_stamp_next, cfg.error_frame_interval))
        begin
            if (cfg.error_pending)
                result.send_error_frame = 1'b1;
            error_stamp_next = item.now;
            if (error_count_next < ERROR_COUNT_MAX)
                error_count_next = error_count_next + ERROR_COUNT_W'(1);
            if (error_count_next > ERROR_LIMIT)
            begin
                bms_power_next    = 1'b0;
                error_active_next = 1'b0;
            end
        end

        if (current_active_next &&
            (item.module_current < cfg.low_current_level ||
             elapsed_over(item.now, current_stamp_next, cfg.current_timeout)))
        begin
            result.output_open  = 1'b1;
            drain_active_next   = 1'b1;
            drain_stamp_next    = item.now;
            current_active_next = 1'b0;
        end

        if (drain_active_next &&
            (item.module_voltage < cfg.safe_voltage_level ||
             elapsed_over(item.now, drain_stamp_next, cfg.drain_timeout)))
        begin
            ended_next        = 1'b1;
            drain_active_next = 1'b0;
        end

        // Go-idle looks at the removal flag from before this pass's connector check.
        if (ended_next && error_count_next > ERROR_LIMIT)
        begin
            lock_next = 1'b0;
            if (removed_next)
                result.go_idle = 1'b1;
        end

        if (!item.connector_present)
        begin
            if (!absent_active_next)
            begin
                absent_active_next = 1'b1;
                absent_stamp_next  = item.now;
            end
        end
        else
        begin
            absent_active_next = 1'b0;
        end

        if (absent_active_next &&
            elapsed_over(item.now, absent_stamp_next, cfg.connector_timeout))
        begin
            result.module_off  = 1'b1;
            result.output_open = 1'b1;
            removed_next       = 1'b1;
            absent_active_next = 1'b0;
        end

        if (item.fault_flags != 7'd0)
        begin
            result.module_off  = 1'b1;
            result.output_open = 1'b1;
        end

        result.bms_power_on = bms_power_next;
        result.lock_on      = lock_next;
        result.charge_ended = ended_next;
        result.gun_removed  = removed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_active_reg    <= 1'b0;
            stop_stamp_reg     <= '0;
            stop_count_reg     <= '0;
            error_active_reg   <= 1'b0;
            error_stamp_reg    <= '0;
            error_count_reg    <= '0;
            current_active_reg <= 1'b0;
            current_stamp_reg  <= '0;
            drain_active_reg   <= 1'b0;
            drain_stamp_reg    <= '0;
            absent_active_reg  <= 1'b0;
            absent_stamp_reg   <= '0;
            ended_reg          <= 1'b0;
            removed_reg        <= 1'b0;
            bms_power_reg      <= 1'b0;
            lock_reg           <= 1'b0;
        end
        else if (step)
        begin
            stop_active_reg    <= stop_active_next;
            stop_stamp_reg     <= stop_stamp_next;
            stop_count_reg     <= stop_count_next;
            error_active_reg   <= error_active_next;
            error_stamp_reg    <= error_stamp_next;
            error_count_reg    <= error_count_next;
            current_active_reg <= current_active_next;
            current_stamp_reg  <= current_stamp_next;
            drain_active_reg   <= drain_active_next;
            drain_stamp_reg    <= drain_stamp_next;
            absent_active_reg  <= absent_active_next;
            absent_stamp_reg   <= absent_stamp_next;
            ended_reg          <= ended_next;
            removed_reg        <= removed_next;
            bms_power_reg      <= bms_power_next;
            lock_reg           <= lock_next;
        end
    end

    // The current watch hands over to the drain watch; both are never armed together.
    `CFSS_ASSERT_IMPL(a_current_drain_exclusive, 1'b1,
                      !(current_active_reg && drain_active_reg))
    // Resends stop as soon as their counts pass the repeat limits.
    `CFSS_ASSERT_IMPL(a_stop_count_bound, stop_active_reg, stop_count_reg <= STOP_LIMIT)
    `CFSS_ASSERT_IMPL(a_error_count_bound, error_active_reg, error_count_reg <= ERROR_LIMIT)

endmodule

// ===== rtl/charger_fault_shutdown_sequencer_top.sv =====
// A transaction accepted into the input stage has its result registered and out_valid set
// when it advances to the result register; a stalled output holds it in the input stage.
// Throughput: one transaction per cycle while out_stall is low; the pass logic between the
// input stage and the result register is a handful of 32-bit subtract-and-compare timers
// working in parallel. Reset (rst_n, asynchronous, active low) empties both stages, clears
// all timers and flags and loads the configuration registers with their default values.
//
// Top level of the charger fault shutdown sequencer.
// Depends on cfss_pkg, cfss_cfg_regs, cfss_pass and the assertion macro header.
`include "charger_fault_shutdown_sequencer_top_assert.svh"

module charger_fault_shutdown_sequencer_top #(
    parameter int unsigned STOP_FRAME_REPEATS  = 50,
    parameter int unsigned ERROR_FRAME_REPEATS = 5
) (
    input  logic        clk,
    input  logic        rst_n,

    // Input channel: one transaction is one pass of the control loop.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        start_req,
    input  logic [31:0] now,
    input  logic [15:0] module_current,
    input  logic [15:0] module_voltage,
    input  logic        connector_present,
    input  logic [6:0]  fault_flags,

    // Output channel: one result transaction for every input transaction.
    output logic        out_valid,
    input  logic        out_stall,
    output logic        send_stop_frame,
    output logic        send_error_frame,
    output logic        bms_power_on,
    output logic        lock_on,
    output logic        module_off,
    output logic        output_open,
    output logic        charge_ended,
    output logic        gun_removed,
    output logic        go_idle,

    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import cfss_pkg::*;

    cfss_cfg_t    cfg;
    cfss_item_t   item_reg;
    logic         item_valid_reg, item_valid_next;
    cfss_result_t pass_result;
    cfss_result_t result_reg;
    logic         out_valid_reg, out_valid_next;
    logic         in_accept;
    logic         advance;

    // The item in the input stage moves on whenever the result register is free or is
    // being emptied in this cycle. Moving on is also what commits the pass to the state.
    assign advance   = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = item_valid_reg && out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    assign item_valid_next = in_accept || (item_valid_reg && !advance);
    assign out_valid_next  = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers carry no reset; their valid bits guard them.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.start_req         <= start_req;
            item_reg.now               <= now;
            item_reg.module_current    <= module_current;
            item_reg.module_voltage    <= module_voltage;
            item_reg.connector_present <= connector_present;
            item_reg.fault_flags       <= fault_flags;
        end
        if (advance)
        begin
            result_reg <= pass_result;
        end
    end

    cfss_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cfss_pass #(
        .STOP_FRAME_REPEATS  (STOP_FRAME_REPEATS),
        .ERROR_FRAME_REPEATS (ERROR_FRAME_REPEATS)
    ) u_pass (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (pass_result)
    );

    assign out_valid        = out_valid_reg;
    assign send_stop_frame  = result_reg.send_stop_frame;
    assign send_error_frame = result_reg.send_error_frame;
    assign bms_power_on     = result_reg.bms_power_on;
    assign lock_on          = result_reg.lock_on;
    assign module_off       = result_reg.module_off;
    assign output_open      = result_reg.output_open;
    assign charge_ended     = result_reg.charge_ended;
    assign gun_removed      = result_reg.gun_removed;
    assign go_idle          = result_reg.go_idle;

    // A stall is only raised while the input stage holds a transaction.
    `CFSS_ASSERT_IMPL(a_stall_needs_item, in_stall, item_valid_reg)
    // A transaction held in the input stage is not dropped while the output is blocked.
    `CFSS_ASSERT_NEXT(a_item_kept, item_valid_reg && !advance, item_valid_reg)
    // Every pass committed to the state produces a result in the next cycle.
    `CFSS_ASSERT_NEXT(a_result_follows, advance, out_valid_reg)

endmodule
